FILE: rtl/core/dssr_pkg.sv
`default_nettype none

package dssr_pkg;

	// default sizes
	localparam int DEF_CAPACITY   = 256;
	localparam int DEF_ITEM_SPACE = 256;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 2'd0,
		CMD_DEL = 2'd1,
		CMD_CLR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 2'd0,
		STS_ALREADY    = 2'd1,
		STS_NOT_MEMBER = 2'd2,
		STS_FULL       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEL,
		ST_CLR,
		ST_CLR_LAST
	} state_t;

	// result packed with the first field in the highest bits
	typedef struct packed {
		logic [COUNT_W-1:0] member_count;
		logic [ID_W-1:0]    moved_item;
		logic               moved_valid;
		logic [SLOT_W-1:0]  slot;
		status_t            status;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/dense_set_swap_remove.sv
`default_nettype none

// Dense set with swap-remove. Keeps up to CAPACITY item ids packed in slots
// 0 .. count-1 in a dense table, plus a position table giving each held item
// its slot; both are single-port-write RAMs with a registered read, and the
// membership flags are flip-flops cleared by reset. Each request (cmd 0 add,
// 1 delete, 2 clear) gives exactly one result. Add, any refused request and
// the unused command need no RAM read, since the flags and the count are in
// flops. Delete reads the position of the item and the entry in the last
// slot from the RAMs, then writes the last entry into the freed slot and
// fixes its position. Clear walks the dense table one slot a cycle through
// its read port and drops each member's flag; an empty set is answered
// without the walk. Results sit in an output register backed by one spare
// register, so a new request is taken while a result waits; requests stall
// only while a delete or clear is in progress or both result registers are
// full. Ids at or above ITEM_SPACE are reported as not member.
module dense_set_swap_remove #(
	parameter int CAPACITY   = dssr_pkg::DEF_CAPACITY,
	parameter int ITEM_SPACE = dssr_pkg::DEF_ITEM_SPACE
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [1:0] cmd, [9:2] item_id, [15:10] zero
	input  wire logic [dssr_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [1:0] status, [9:2] slot, [10] moved_valid, [18:11] moved_item,
	// [27:19] member_count, [31:28] zero
	output logic [dssr_pkg::OUT_DATA_W-1:0]        m_tdata
);

	// ids are 8 bits wide, so at most 256 of the item space is reachable
	localparam int ISP = (ITEM_SPACE < 256) ? ITEM_SPACE : 256;
	localparam int IW  = (ISP > 1) ? $clog2(ISP) : 1;
	localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int RES_W = $bits(dssr_pkg::res_t);

	// storage
	logic [IW-1:0] dense_mem [CAPACITY];
	logic [SW-1:0] pos_mem   [ISP];
	logic [ISP-1:0] flag_q;
	logic [CW-1:0]  total_q;

	// control
	dssr_pkg::state_t state_q, state_d;
	logic [IW-1:0]    id_q;
	logic [CW-1:0]    clr_idx_q;

	// registered RAM reads
	logic [IW-1:0] dense_rd_s1;
	logic [SW-1:0] pos_rd_s1;

	// result registers
	logic            out_valid_q, spare_valid_q;
	dssr_pkg::res_t  out_q, spare_q;

	// request decode
	logic               acc;
	dssr_pkg::cmd_t     cmd_in;
	logic [7:0]         id_in;
	logic               id_ok;
	logic [IW-1:0]      fidx;
	logic               is_mem;
	logic               full;
	logic [CW-1:0]      last;

	// datapath controls
	logic               res_fire;
	dssr_pkg::res_t     res;
	logic               dense_we;
	logic [SW-1:0]      dense_wa;
	logic [IW-1:0]      dense_wd;
	logic [SW-1:0]      dense_ra;
	logic               pos_we;
	logic [IW-1:0]      pos_wa;
	logic [SW-1:0]      pos_wd;
	logic               flag_set, flag_clr;
	logic [IW-1:0]      flag_idx;
	logic               total_we;
	logic [CW-1:0]      total_d;
	logic               clr_start;
	logic               out_take;

	assign s_tready = (state_q == dssr_pkg::ST_IDLE) && !spare_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign cmd_in   = dssr_pkg::cmd_t'(s_tdata[1:0]);
	assign id_in    = s_tdata[9:2];
	assign id_ok    = 32'(id_in) < ISP;
	assign fidx     = IW'(id_in);
	assign is_mem   = id_ok && flag_q[fidx];
	assign full     = 32'(total_q) >= CAPACITY;
	assign last     = total_q - CW'(1);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(dssr_pkg::OUT_DATA_W - RES_W)'(0), out_q};
	assign out_take = m_tvalid && m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dssr_pkg::ST_IDLE: begin
				if (acc && cmd_in == dssr_pkg::CMD_DEL && is_mem) begin
					state_d = dssr_pkg::ST_DEL;
				end else if (acc && cmd_in == dssr_pkg::CMD_CLR && total_q != '0) begin
					state_d = dssr_pkg::ST_CLR;
				end
			end
			dssr_pkg::ST_DEL: begin
				state_d = dssr_pkg::ST_IDLE;
			end
			dssr_pkg::ST_CLR: begin
				if (clr_idx_q == last) begin
					state_d = dssr_pkg::ST_CLR_LAST;
				end
			end
			dssr_pkg::ST_CLR_LAST: begin
				state_d = dssr_pkg::ST_IDLE;
			end
			default: begin
				state_d = dssr_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath controls and result
	always_comb begin
		res_fire  = 1'b0;
		res       = '0;
		res.status = dssr_pkg::STS_OK;
		res.member_count = 9'(total_q);
		dense_we  = 1'b0;
		dense_wa  = SW'(total_q);
		dense_wd  = fidx;
		dense_ra  = SW'(last);
		pos_we    = 1'b0;
		pos_wa    = fidx;
		pos_wd    = SW'(total_q);
		flag_set  = 1'b0;
		flag_clr  = 1'b0;
		flag_idx  = fidx;
		total_we  = 1'b0;
		total_d   = total_q;
		clr_start = 1'b0;
		case (state_q)
			dssr_pkg::ST_IDLE: begin
				if (acc) begin
					case (cmd_in)
						dssr_pkg::CMD_ADD: begin
							res_fire = 1'b1;
							if (!id_ok) begin
								res.status = dssr_pkg::STS_NOT_MEMBER;
							end else if (flag_q[fidx]) begin
								res.status = dssr_pkg::STS_ALREADY;
							end else if (full) begin
								res.status = dssr_pkg::STS_FULL;
							end else begin
								dense_we = 1'b1;
								pos_we   = 1'b1;
								flag_set = 1'b1;
								total_we = 1'b1;
								total_d  = total_q + CW'(1);
								res.slot = 8'(total_q);
								res.member_count = 9'(total_d);
							end
						end
						dssr_pkg::CMD_DEL: begin
							// members continue in ST_DEL once the RAM reads land
							if (!is_mem) begin
								res_fire   = 1'b1;
								res.status = dssr_pkg::STS_NOT_MEMBER;
							end
						end
						dssr_pkg::CMD_CLR: begin
							clr_start = 1'b1;
							if (total_q == '0) begin
								res_fire = 1'b1;
							end
						end
						default: begin
							res_fire = 1'b1;
						end
					endcase
				end
			end
			dssr_pkg::ST_DEL: begin
				// pos_rd_s1 is the freed slot, dense_rd_s1 the last entry
				res_fire = 1'b1;
				flag_clr = 1'b1;
				flag_idx = id_q;
				total_we = 1'b1;
				total_d  = last;
				res.slot = 8'(pos_rd_s1);
				res.member_count = 9'(last);
				if (CW'(pos_rd_s1) != last) begin
					dense_we = 1'b1;
					dense_wa = pos_rd_s1;
					dense_wd = dense_rd_s1;
					pos_we   = 1'b1;
					pos_wa   = dense_rd_s1;
					pos_wd   = pos_rd_s1;
					res.moved_valid = 1'b1;
					res.moved_item  = 8'(dense_rd_s1);
				end
			end
			dssr_pkg::ST_CLR: begin
				// read slot clr_idx_q, drop the flag of the slot read last cycle
				dense_ra = SW'(clr_idx_q);
				flag_idx = dense_rd_s1;
				flag_clr = clr_idx_q != '0;
			end
			dssr_pkg::ST_CLR_LAST: begin
				res_fire = 1'b1;
				flag_idx = dense_rd_s1;
				flag_clr = 1'b1;
				total_we = 1'b1;
				total_d  = '0;
				res.member_count = '0;
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	// dense table
	always_ff @(posedge clk) begin
		if (dense_we) begin
			dense_mem[dense_wa] <= dense_wd;
		end
		dense_rd_s1 <= dense_mem[dense_ra];
	end

	// position table
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		pos_rd_s1 <= pos_mem[fidx];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dssr_pkg::ST_IDLE;
			flag_q    <= '0;
			total_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (flag_set) begin
				flag_q[flag_idx] <= 1'b1;
			end else if (flag_clr) begin
				flag_q[flag_idx] <= 1'b0;
			end
			if (total_we) begin
				total_q <= total_d;
			end
			if (clr_start) begin
				clr_idx_q <= '0;
			end else if (state_q == dssr_pkg::ST_CLR) begin
				clr_idx_q <= clr_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			id_q <= fidx;
		end
	end

	// output register plus spare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (res_fire) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					spare_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q   <= spare_valid_q;
				spare_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				spare_q <= res;
			end
		end else if (out_take && spare_valid_q) begin
			out_q <= spare_q;
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CAPACITY   = dssr_pkg::DEF_CAPACITY;
	localparam int ITEM_SPACE = dssr_pkg::DEF_ITEM_SPACE;

	// cmd 3 has no enum member; it must still come back as a plain ok
	localparam logic [dssr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Shadow copy of the dense set. Each accepted request is applied here and the
	// result it must produce is queued; results from the block are popped in order.
	class set_tracker;
		logic [dssr_pkg::ID_W-1:0] entry_at_slot [CAPACITY];
		int unsigned               slot_of_item [ITEM_SPACE];
		bit                        is_member [ITEM_SPACE];
		int unsigned               members;
		dssr_pkg::res_t            results_due [$];
		int                        errors;

		function new();
			members = 0;
			errors  = 0;
			foreach (is_member[k]) is_member[k] = 1'b0;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// caller makes sure the set is not empty
		function logic [dssr_pkg::ID_W-1:0] any_member();
			return entry_at_slot[$urandom_range(0, members - 1)];
		endfunction

		// an id not held right now, if one turns up quickly
		function logic [dssr_pkg::ID_W-1:0] any_outsider();
			logic [dssr_pkg::ID_W-1:0] id;
			id = dssr_pkg::ID_W'($urandom);
			for (int k = 0; k < 64 && is_member[id]; k++)
				id = dssr_pkg::ID_W'($urandom);
			return id;
		endfunction

		function void take_request(logic [dssr_pkg::IN_DATA_W-1:0] data);
			logic [dssr_pkg::CMD_W-1:0] op;
			logic [dssr_pkg::ID_W-1:0]  id;
			logic [dssr_pkg::ID_W-1:0]  mover;
			int unsigned                p;
			dssr_pkg::res_t             r;
			op = data[1:0];
			id = data[9:2];
			r  = '0;
			case (op)
				dssr_pkg::CMD_ADD: begin
					// membership is checked ahead of capacity
					if (is_member[id]) begin
						r.status = dssr_pkg::STS_ALREADY;
					end else if (members >= CAPACITY) begin
						r.status = dssr_pkg::STS_FULL;
					end else begin
						entry_at_slot[members] = id;
						slot_of_item[id]       = members;
						is_member[id]          = 1'b1;
						r.slot                 = members[dssr_pkg::SLOT_W-1:0];
						members++;
					end
				end
				dssr_pkg::CMD_DEL: begin
					p = slot_of_item[id];
					if (!is_member[id] || p >= members || entry_at_slot[p] != id) begin
						r.status = dssr_pkg::STS_NOT_MEMBER;
					end else begin
						// swap-remove: last entry fills the hole unless it is the hole
						mover         = entry_at_slot[members - 1];
						is_member[id] = 1'b0;
						members--;
						r.slot        = p[dssr_pkg::SLOT_W-1:0];
						if (p != members) begin
							entry_at_slot[p]     = mover;
							slot_of_item[mover]  = p;
							r.moved_valid        = 1'b1;
							r.moved_item         = mover;
						end
					end
				end
				dssr_pkg::CMD_CLR: begin
					for (int k = 0; k < members; k++)
						is_member[entry_at_slot[k]] = 1'b0;
					members = 0;
				end
				default: ;
			endcase
			r.member_count = members[dssr_pkg::COUNT_W-1:0];
			results_due = {results_due, r};
		endfunction

		function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch %0d at %0t: %s expected 0x%0h got 0x%0h",
					errors, $time, what, want, got);
		endfunction

		function void check_result(logic [dssr_pkg::OUT_DATA_W-1:0] data);
			dssr_pkg::res_t got, want;
			got = dssr_pkg::res_t'(data[$bits(dssr_pkg::res_t)-1:0]);
			if (results_due.size() == 0) begin
				note_mismatch("result with no request outstanding", '0, data);
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status)
				note_mismatch("status", want.status, got.status);
			if (got.slot !== want.slot)
				note_mismatch("slot", want.slot, got.slot);
			if (got.moved_valid !== want.moved_valid)
				note_mismatch("moved_valid", want.moved_valid, got.moved_valid);
			if (got.moved_item !== want.moved_item)
				note_mismatch("moved_item", want.moved_item, got.moved_item);
			if (got.member_count !== want.member_count)
				note_mismatch("member_count", want.member_count, got.member_count);
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	// [1:0] cmd, [9:2] item_id, [15:10] zero
	logic [dssr_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	// [1:0] status, [9:2] slot, [10] moved_valid, [18:11] moved_item,
	// [27:19] member_count, [31:28] zero
	logic [dssr_pkg::OUT_DATA_W-1:0] m_tdata;

	set_tracker book = new();

	int gap_pct   = 0;   // chance of a sender gap after each request
	bit calm      = 1'b0; // final stretch: no idling on either side
	bit hold_sink = 1'b0; // asks the sink for one long hold-off

	dense_set_swap_remove dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs; a correct run needs far less
	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Both handshakes are sampled at the edge, before any of this step's updates land.
	// Results are checked before the same edge's request is applied: a result
	// leaving now can never belong to a request entering now.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				book.check_result(m_tdata);
			if (s_tvalid && s_tready)
				book.take_request(s_tdata);
		end
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 6;
			default: return 25;
		endcase
	endfunction

	// Offer one request and hold it until taken; maybe idle for a burst afterwards.
	// s_tvalid gets one assignment per step, so back-to-back requests keep it high.
	task automatic send_req(input logic [dssr_pkg::CMD_W-1:0] op,
		input logic [dssr_pkg::ID_W-1:0] id);
		s_tdata  <= {6'b0, id, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// drop valid so the last request is not taken again; one edge first so the
	// request taken at the current edge is already queued
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Random traffic, mostly well formed: adds aim at ids not held, deletes at
	// held ids, so the set grows and shrinks and the swap path sees real data.
	// The rest are clears, the unused command and blind adds/deletes.
	task automatic run_mix(input int n);
		int roll;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				gap_pct = pick_pct();
			roll = $urandom_range(0, 99);
			if (roll < 45)
				send_req(dssr_pkg::CMD_ADD,
					roll < 32 ? book.any_outsider() : dssr_pkg::ID_W'($urandom));
			else if (roll < 80)
				send_req(dssr_pkg::CMD_DEL, (roll < 70 && book.members > 0) ?
					book.any_member() : dssr_pkg::ID_W'($urandom));
			else if (roll < 84)
				send_req(dssr_pkg::CMD_CLR, dssr_pkg::ID_W'($urandom));
			else if (roll < 88)
				send_req(CMD_UNUSED, dssr_pkg::ID_W'($urandom));
			else
				send_req(roll[0] ? dssr_pkg::CMD_DEL : dssr_pkg::CMD_ADD,
					dssr_pkg::ID_W'($urandom));
		end
	endtask

	// Result side: stretches of random length, each with its own stall rate
	// (zero included). A hold request from the stimulus drops tready for one
	// long hold-off so the block backs up and stalls its input.
	initial begin : sink
		int stretch;
		int pct;
		int burst;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stretch = $urandom_range(20, 200);
			pct     = pick_pct();
			while (stretch > 0) begin
				if (hold_sink) begin
					m_tready <= 1'b0;
					repeat (300) @(posedge clk);
					hold_sink = 1'b0;
					stretch   = 0;
				end else if (!calm && $urandom_range(0, 99) < pct) begin
					burst = $urandom_range(1, 18);
					m_tready <= 1'b0;
					repeat (burst) @(posedge clk);
					stretch -= burst;
				end else begin
					m_tready <= 1'b1;
					@(posedge clk);
					stretch--;
				end
			end
		end
	end

	initial begin : stimulus
		logic [dssr_pkg::ID_W-1:0] order [ITEM_SPACE];
		logic [dssr_pkg::ID_W-1:0] swap;
		int                        j;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of the id, every command, refusals, swap and no-swap deletes
		gap_pct = 10;
		send_req(dssr_pkg::CMD_CLR, 8'h00);    // clear of an empty set
		send_req(dssr_pkg::CMD_DEL, 8'h00);    // delete from an empty set
		send_req(dssr_pkg::CMD_ADD, 8'h00);
		send_req(dssr_pkg::CMD_ADD, 8'hff);
		send_req(dssr_pkg::CMD_ADD, 8'h00);    // already held
		send_req(dssr_pkg::CMD_DEL, 8'hff);    // sits in the last slot: nothing moves
		send_req(dssr_pkg::CMD_ADD, 8'hff);    // deleted id can come back
		send_req(dssr_pkg::CMD_ADD, 8'haa);
		send_req(dssr_pkg::CMD_ADD, 8'h55);
		send_req(dssr_pkg::CMD_DEL, 8'h00);    // slot 0 freed, 8'h55 moved in
		send_req(dssr_pkg::CMD_DEL, 8'h55);    // slot 0 again, 8'haa moved in
		send_req(dssr_pkg::CMD_DEL, 8'h55);    // gone already
		send_req(CMD_UNUSED, 8'hff);
		send_req(CMD_UNUSED, 8'h00);
		send_req(dssr_pkg::CMD_ADD, 8'h01);
		send_req(dssr_pkg::CMD_ADD, 8'h80);
		send_req(dssr_pkg::CMD_DEL, 8'hff);
		send_req(dssr_pkg::CMD_CLR, 8'hff);    // clear with members
		send_req(dssr_pkg::CMD_ADD, 8'hff);    // cleared id is free again
		send_req(dssr_pkg::CMD_DEL, 8'h07);
		send_req(dssr_pkg::CMD_ADD, 8'hfe);
		send_req(dssr_pkg::CMD_CLR, 8'h00);

		// sender goes quiet until the block has answered everything
		wait_drained();
		run_mix(200);

		// long sink hold-off while requests keep coming back to back
		gap_pct   = 0;
		hold_sink = 1'b1;
		for (int k = 0; k < 16; k++)
			send_req(dssr_pkg::CMD_ADD, book.any_outsider());
		while (hold_sink) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end

		// fill the store with every id in shuffled order; count reaches its top
		send_req(dssr_pkg::CMD_CLR, dssr_pkg::ID_W'($urandom));
		for (int k = 0; k < ITEM_SPACE; k++)
			order[k] = k[dssr_pkg::ID_W-1:0];
		for (int k = ITEM_SPACE - 1; k > 0; k--) begin
			j        = $urandom_range(0, k);
			swap     = order[k];
			order[k] = order[j];
			order[j] = swap;
		end
		gap_pct = pick_pct();
		for (int k = 0; k < ITEM_SPACE; k++)
			send_req(dssr_pkg::CMD_ADD, order[k]);
		// full store: every id is held, so adds come back as already held
		for (int k = 0; k < 4; k++)
			send_req(dssr_pkg::CMD_ADD, dssr_pkg::ID_W'($urandom));
		send_req(dssr_pkg::CMD_DEL, order[ITEM_SPACE - 1]);  // top slot, no move
		send_req(dssr_pkg::CMD_ADD, order[ITEM_SPACE - 1]);  // refills to the top
		send_req(dssr_pkg::CMD_DEL, order[0]);               // slot 0 from the top slot

		run_mix(200);

		// last part with no idling anywhere
		calm = 1'b1;
		run_mix(130);

		wait_drained();
		repeat (20) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
